/* rtl/tvrt_pkg.sv */
// Shared types, constants and state codes for the two-level voxel ray traversal block.
`default_nettype none
package tvrt_pkg;

	// Default grid geometry
	localparam int CHUNK_EDGE_D = 8;
	localparam int CHUNKS_X_D   = 8;
	localparam int CHUNKS_Y_D   = 8;
	localparam int CHUNKS_Z_D   = 8;

	localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;
	localparam logic [11:0] LIMIT_RST = 12'd256;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	// Register indexes
	localparam logic [1:0] REG_CAM_X = 2'd0;
	localparam logic [1:0] REG_CAM_Y = 2'd1;
	localparam logic [1:0] REG_CAM_Z = 2'd2;
	localparam logic [1:0] REG_LIMIT = 2'd3;

	typedef struct packed {
		logic               command;
		logic [5:0]         write_x;
		logic [5:0]         write_y;
		logic [5:0]         write_z;
		logic [3:0]         write_block;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} cmd_t;

	typedef struct packed {
		logic        hit;
		logic [5:0]  hit_x;
		logic [5:0]  hit_y;
		logic [5:0]  hit_z;
		logic [1:0]  hit_face;
		logic        neg_x;
		logic        neg_y;
		logic        neg_z;
		logic [3:0]  hit_block;
		logic [23:0] distance;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_TMAX,
		ST_RD,
		ST_EV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* rtl/two_level_voxel_ray_traversal.sv */
// Top level: voxel store, chunk counts, write path and ray walk sequencer.
`default_nettype none
// After reset the block runs a clearing pass over every address of the voxel store,
// during which cmd_stall stays high; configuration writes are taken throughout. A write
// transaction accepts the command, reads the old voxel and chunk count, then writes
// both back. A cast is accepted, then set up through the shared bit-serial divider
// (28 quotient bits) and multiplier that compute the per-axis step distances one
// axis after another, then walks with a read and an evaluate step per voxel visited
// (registered reads of the chunk count and voxel RAMs), and finally posts the result.
// One transaction is processed at a time.
module two_level_voxel_ray_traversal #(
	parameter int CHUNK_EDGE = tvrt_pkg::CHUNK_EDGE_D,
	parameter int CHUNKS_X   = tvrt_pkg::CHUNKS_X_D,
	parameter int CHUNKS_Y   = tvrt_pkg::CHUNKS_Y_D,
	parameter int CHUNKS_Z   = tvrt_pkg::CHUNKS_Z_D
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire tvrt_pkg::cmd_t  cmd,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output tvrt_pkg::res_t       res,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [21:0]     cfg_data
);
	localparam int WX   = CHUNK_EDGE * CHUNKS_X;
	localparam int WY   = CHUNK_EDGE * CHUNKS_Y;
	localparam int WZ   = CHUNK_EDGE * CHUNKS_Z;
	localparam int VD   = WX * WY * WZ;
	localparam int CD   = CHUNKS_X * CHUNKS_Y * CHUNKS_Z;
	localparam int VAW  = $clog2(VD);
	localparam int CAW  = CD > 1 ? $clog2(CD) : 1;
	localparam int CNTW = $clog2(CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE + 1);
	localparam int WM1  = WX > WY ? WX : WY;
	localparam int WM2  = WM1 > WZ ? WM1 : WZ;
	localparam int WMAX = WM2 > 64 ? WM2 : 64;
	localparam int CW   = $clog2(WMAX + 1) + 1;
	localparam int RS   = CW + 10;
	localparam int RM   = ((1 << RS) + CHUNK_EDGE - 1) / CHUNK_EDGE;
	localparam int PW   = CW - 1 + RS;

	// Chunk coordinate by reciprocal multiplication (exact over the coordinate range)
	function automatic logic [CW-2:0] chunk_of(input logic [CW-2:0] v);
		logic [PW-1:0] p;
		p = PW'(v) * PW'(RM);
		return (CW-1)'(p >> RS);
	endfunction

	tvrt_pkg::state_t state_q, state_d;

	logic [21:0]           cam_q [3];
	logic [11:0]           limit_q;
	logic [VAW-1:0]        wv_addr_q;
	logic [CAW-1:0]        wc_addr_q;
	logic [3:0]            wblk_q;
	logic signed [15:0]    dir_q [3];
	logic signed [CW-1:0]  pos_q [3];
	logic [23:0]           delta_q [3];
	logic [23:0]           tmax_q [3];
	logic                  neg_q [3];
	logic [1:0]            face_q;
	logic [11:0]           steps_q;
	logic [1:0]            ax_q;
	logic [40:0]           prod_q;
	logic [VAW-1:0]        clr_q;
	tvrt_pkg::res_t        rslt_q;
	tvrt_pkg::res_t        res_q;
	logic                  res_valid_q;

	// RAM ports
	logic            v_we, c_we;
	logic [VAW-1:0]  v_addr;
	logic [CAW-1:0]  c_addr;
	logic [3:0]      v_wdata, v_rdata;
	logic [CNTW-1:0] c_wdata, c_rdata;

	logic            div_start, div_done;
	logic [15:0]     div_mag;
	logic [23:0]     div_quot;

	tvrt_ram #(.WIDTH(4), .DEPTH(VD)) u_vox (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
	);

	tvrt_ram #(.WIDTH(CNTW), .DEPTH(CD)) u_cnt (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
	);

	tvrt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .mag(div_mag),
		.done(div_done), .quot(div_quot)
	);

	// Walk position: world test and addresses
	logic            in_world;
	logic [CW-2:0]   ux, uy, uz;
	logic [VAW-1:0]  walk_vaddr;
	logic [CAW-1:0]  walk_caddr;

	assign in_world = !pos_q[0][CW-1] && !pos_q[1][CW-1] && !pos_q[2][CW-1] &&
		(pos_q[0] < $signed(CW'(WX))) && (pos_q[1] < $signed(CW'(WY))) &&
		(pos_q[2] < $signed(CW'(WZ)));
	assign ux = pos_q[0][CW-2:0];
	assign uy = pos_q[1][CW-2:0];
	assign uz = pos_q[2][CW-2:0];
	assign walk_vaddr = VAW'((int'(uz) * WY + int'(uy)) * WX + int'(ux));
	assign walk_caddr = CAW'((int'(chunk_of(uz)) * CHUNKS_Y + int'(chunk_of(uy))) *
		CHUNKS_X + int'(chunk_of(ux)));

	// Write command addresses
	logic            wr_in_world;
	logic [CW-2:0]   wx, wy, wz;
	assign wx = (CW-1)'(cmd.write_x);
	assign wy = (CW-1)'(cmd.write_y);
	assign wz = (CW-1)'(cmd.write_z);
	assign wr_in_world = (int'(cmd.write_x) < WX) && (int'(cmd.write_y) < WY) &&
		(int'(cmd.write_z) < WZ);

	// Axis selection and step
	logic [1:0]  sel;
	logic [24:0] tsum;
	logic [23:0] tnext;
	logic [3:0]  blk;
	logic [23:0] hdist;

	always_comb begin
		if (tmax_q[0] < tmax_q[1] && tmax_q[0] < tmax_q[2]) begin
			sel = 2'd0;
		end else if (tmax_q[1] < tmax_q[2]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end
	assign tsum  = {1'b0, tmax_q[sel]} + {1'b0, delta_q[sel]};
	assign tnext = tsum[24] ? tvrt_pkg::DIST_MAX : tsum[23:0];
	assign blk   = (c_rdata != '0) ? v_rdata : 4'd0;
	always_comb begin
		if (steps_q == '0) begin
			hdist = '0;
		end else if (tmax_q[face_q] == tvrt_pkg::DIST_MAX) begin
			hdist = tvrt_pkg::DIST_MAX;
		end else begin
			hdist = tmax_q[face_q] - delta_q[face_q];
		end
	end

	// Set-up multiplier operand: distance to the first boundary
	logic [16:0] fdist;
	logic [15:0] frac;
	assign frac  = cam_q[ax_q][15:0];
	assign fdist = neg_q[ax_q] ? {1'b0, frac} : 17'h10000 - {1'b0, frac};
	assign div_mag = dir_q[ax_q][15] ? 16'(-dir_q[ax_q]) : dir_q[ax_q];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvrt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control
	always_comb begin
		state_d   = state_q;
		v_we      = 1'b0;
		c_we      = 1'b0;
		v_addr    = walk_vaddr;
		c_addr    = walk_caddr;
		v_wdata   = '0;
		c_wdata   = '0;
		div_start = 1'b0;
		case (state_q)
			tvrt_pkg::ST_CLEAR: begin
				v_we   = 1'b1;
				v_addr = clr_q;
				c_we   = (int'(clr_q) < CD);
				c_addr = CAW'(clr_q);
				if (clr_q == VAW'(VD - 1)) begin
					state_d = tvrt_pkg::ST_IDLE;
				end
			end
			tvrt_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.command == tvrt_pkg::CMD_CAST) begin
						state_d = tvrt_pkg::ST_DIV_GO;
					end else if (wr_in_world) begin
						state_d = tvrt_pkg::ST_WR_RD;
					end
				end
			end
			tvrt_pkg::ST_WR_RD: begin
				v_addr  = wv_addr_q;
				c_addr  = wc_addr_q;
				state_d = tvrt_pkg::ST_WR_WB;
			end
			tvrt_pkg::ST_WR_WB: begin
				v_addr  = wv_addr_q;
				c_addr  = wc_addr_q;
				v_we    = 1'b1;
				v_wdata = wblk_q;
				c_we    = 1'b1;
				c_wdata = c_rdata;
				if (v_rdata != '0 && wblk_q == '0 && c_rdata != '0) begin
					c_wdata = c_rdata - CNTW'(1);
				end else if (v_rdata == '0 && wblk_q != '0) begin
					c_wdata = c_rdata + CNTW'(1);
				end
				state_d = tvrt_pkg::ST_IDLE;
			end
			tvrt_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = tvrt_pkg::ST_DIV_WAIT;
			end
			tvrt_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = tvrt_pkg::ST_MUL;
				end
			end
			tvrt_pkg::ST_MUL: begin
				state_d = tvrt_pkg::ST_TMAX;
			end
			tvrt_pkg::ST_TMAX: begin
				state_d = (ax_q == 2'd2) ? tvrt_pkg::ST_RD : tvrt_pkg::ST_DIV_GO;
			end
			tvrt_pkg::ST_RD: begin
				state_d = in_world ? tvrt_pkg::ST_EV : tvrt_pkg::ST_DONE;
			end
			tvrt_pkg::ST_EV: begin
				if (blk != '0 || steps_q >= limit_q) begin
					state_d = tvrt_pkg::ST_DONE;
				end else begin
					state_d = tvrt_pkg::ST_RD;
				end
			end
			tvrt_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					state_d = tvrt_pkg::ST_IDLE;
				end
			end
			default: state_d = tvrt_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0]    <= '0;
			cam_q[1]    <= '0;
			cam_q[2]    <= '0;
			limit_q     <= tvrt_pkg::LIMIT_RST;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tvrt_pkg::REG_CAM_X: cam_q[0] <= cfg_data;
					tvrt_pkg::REG_CAM_Y: cam_q[1] <= cfg_data;
					tvrt_pkg::REG_CAM_Z: cam_q[2] <= cfg_data;
					tvrt_pkg::REG_LIMIT: limit_q  <= cfg_data[11:0];
					default: ;
				endcase
			end
			if (state_q == tvrt_pkg::ST_CLEAR) begin
				clr_q <= clr_q + VAW'(1);
			end
			if (state_q == tvrt_pkg::ST_DONE && (!res_valid_q || !res_stall)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tvrt_pkg::ST_IDLE: begin
				wv_addr_q <= VAW'((int'(wz) * WY + int'(wy)) * WX + int'(wx));
				wc_addr_q <= CAW'((int'(chunk_of(wz)) * CHUNKS_Y + int'(chunk_of(wy))) *
					CHUNKS_X + int'(chunk_of(wx)));
				wblk_q    <= cmd.write_block;
				dir_q[0]  <= cmd.dir_x;
				dir_q[1]  <= cmd.dir_y;
				dir_q[2]  <= cmd.dir_z;
				neg_q[0]  <= (cmd.dir_x <= 16'sd0);
				neg_q[1]  <= (cmd.dir_y <= 16'sd0);
				neg_q[2]  <= (cmd.dir_z <= 16'sd0);
				for (int i = 0; i < 3; i++) begin
					pos_q[i] <= $signed(CW'(cam_q[i][21:16]));
				end
				ax_q      <= '0;
				steps_q   <= '0;
				face_q    <= '0;
			end
			tvrt_pkg::ST_DIV_WAIT: begin
				delta_q[ax_q] <= div_quot;
			end
			tvrt_pkg::ST_MUL: begin
				prod_q <= 41'(fdist) * 41'(delta_q[ax_q]);
			end
			tvrt_pkg::ST_TMAX: begin
				if (delta_q[ax_q] == tvrt_pkg::DIST_MAX || prod_q[40] != 1'b0) begin
					tmax_q[ax_q] <= tvrt_pkg::DIST_MAX;
				end else begin
					tmax_q[ax_q] <= prod_q[39:16];
				end
				ax_q <= ax_q + 2'd1;
			end
			tvrt_pkg::ST_RD: begin
				// Miss record, kept if the walk ends here or without a hit
				rslt_q          <= '0;
				rslt_q.distance <= tvrt_pkg::DIST_MAX;
			end
			tvrt_pkg::ST_EV: begin
				if (blk != '0) begin
					rslt_q.hit       <= 1'b1;
					rslt_q.hit_x     <= 6'(ux);
					rslt_q.hit_y     <= 6'(uy);
					rslt_q.hit_z     <= 6'(uz);
					rslt_q.hit_face  <= (steps_q == '0) ? 2'd0 : face_q;
					rslt_q.neg_x     <= neg_q[0];
					rslt_q.neg_y     <= neg_q[1];
					rslt_q.neg_z     <= neg_q[2];
					rslt_q.hit_block <= blk;
					rslt_q.distance  <= hdist;
				end else if (steps_q < limit_q) begin
					pos_q[sel]  <= neg_q[sel] ? pos_q[sel] - CW'(1) : pos_q[sel] + CW'(1);
					tmax_q[sel] <= tnext;
					face_q      <= sel;
					steps_q     <= steps_q + 12'd1;
				end
			end
			tvrt_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					res_q <= rslt_q;
				end
			end
			default: ;
		endcase
	end

	assign cmd_stall = (state_q != tvrt_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A miss always reports the largest distance and no block
	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.distance == tvrt_pkg::DIST_MAX && res.hit_block == 4'd0)
		else $error("miss result with wrong distance or block");

	// A hit never reports air
	a_hit_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |-> res.hit_block != 4'd0)
		else $error("hit result with air block");

	// The walk never starts a step past the limit
	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tvrt_pkg::ST_EV |-> steps_q <= limit_q || $past(cfg_we))
		else $error("walk went past the step limit");

	// A new result is only posted into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		$past(res_valid) && $past(res_stall) |-> $stable(res))
		else $error("output overwritten while stalled");
endmodule
`default_nettype wire

/* rtl/tvrt_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module tvrt_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 512
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                      wdata,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* rtl/tvrt_div.sv */
// Bit-serial restoring divider: saturated 2^27 / mag, one quotient bit per cycle.
`default_nettype none
module tvrt_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] mag,
	output logic             done,
	output logic [23:0]      quot
);
	logic        run_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] mag_q;
	logic [27:0] q_q;
	logic [16:0] rem2;

	// Next partial remainder: numerator has its only one at bit 27
	assign rem2 = {rem_q, (cnt_q == 5'd27)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd27;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= '0;
			mag_q <= mag;
		end else if (run_q) begin
			if (rem2 >= {1'b0, mag_q}) begin
				rem_q <= 16'(rem2 - {1'b0, mag_q});
				q_q   <= {q_q[26:0], 1'b1};
			end else begin
				rem_q <= rem2[15:0];
				q_q   <= {q_q[26:0], 1'b0};
			end
		end
	end

	assign quot = (mag_q == '0 || q_q[27:24] != '0) ? tvrt_pkg::DIST_MAX : q_q[23:0];
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for the two-level voxel ray traversal block: prediction scoreboard and stimulus.
`timescale 1ns / 100ps

// Predicts cast results from a private copy of the grid and registers.
class ray_scoreboard;
	bit [3:0]  grid [int];
	int unsigned solid_cnt [512];
	bit [21:0] cam [3];
	bit [11:0] limit;
	tvrt_pkg::res_t pending [$];
	int        errors;
	int        casts_checked;
	int        hits_seen;

	function void clear_state();
		grid.delete();
		foreach (solid_cnt[i]) solid_cnt[i] = 0;
		cam[0] = 0; cam[1] = 0; cam[2] = 0;
		limit = tvrt_pkg::LIMIT_RST;
		errors = 0;
		casts_checked = 0;
		hits_seen = 0;
	endfunction

	function void set_reg(bit [1:0] idx, bit [21:0] val);
		case (idx)
			tvrt_pkg::REG_CAM_X: cam[0] = val;
			tvrt_pkg::REG_CAM_Y: cam[1] = val;
			tvrt_pkg::REG_CAM_Z: cam[2] = val;
			tvrt_pkg::REG_LIMIT: limit = val[11:0];
			default: ;
		endcase
	endfunction

	function bit [3:0] cell_at(int x, int y, int z);
		int k;
		k = (z * 64 + y) * 64 + x;
		return grid.exists(k) ? grid[k] : 4'd0;
	endfunction

	function int chunk_of(int x, int y, int z);
		return ((z / 8) * 8 + y / 8) * 8 + x / 8;
	endfunction

	// Per-axis step distance and first boundary distance
	function void axis_prep(bit signed [15:0] d, bit [21:0] p, output int step,
			output longint dlt, output longint tm);
		longint mag, f;
		mag = (d < 0) ? -longint'(d) : longint'(d);
		step = (d > 0) ? 1 : -1;
		if (mag == 0) dlt = tvrt_pkg::DIST_MAX;
		else begin
			dlt = (64'd1 << 27) / mag;
			if (dlt > tvrt_pkg::DIST_MAX) dlt = tvrt_pkg::DIST_MAX;
		end
		if (dlt == tvrt_pkg::DIST_MAX) tm = tvrt_pkg::DIST_MAX;
		else begin
			f = (d > 0) ? (65536 - p[15:0]) : p[15:0];
			tm = (f * dlt) >> 16;
			if (tm > tvrt_pkg::DIST_MAX) tm = tvrt_pkg::DIST_MAX;
		end
	endfunction

	function tvrt_pkg::res_t trace_ray(tvrt_pkg::cmd_t c);
		tvrt_pkg::res_t r;
		int pos [3];
		int stp [3];
		longint dlt [3];
		longint tm [3];
		int steps, face, a;
		bit [3:0] b;
		r = '0;
		r.distance = tvrt_pkg::DIST_MAX;
		steps = 0;
		face = 0;
		for (int i = 0; i < 3; i++) pos[i] = cam[i][21:16];
		axis_prep(c.dir_x, cam[0], stp[0], dlt[0], tm[0]);
		axis_prep(c.dir_y, cam[1], stp[1], dlt[1], tm[1]);
		axis_prep(c.dir_z, cam[2], stp[2], dlt[2], tm[2]);
		forever begin
			if (pos[0] < 0 || pos[1] < 0 || pos[2] < 0 ||
					pos[0] > 63 || pos[1] > 63 || pos[2] > 63) break;
			b = 0;
			if (solid_cnt[chunk_of(pos[0], pos[1], pos[2])] != 0)
				b = cell_at(pos[0], pos[1], pos[2]);
			if (b != 0) begin
				r.hit = 1;
				r.hit_x = 6'(pos[0]);
				r.hit_y = 6'(pos[1]);
				r.hit_z = 6'(pos[2]);
				r.hit_face = (steps == 0) ? 2'd0 : 2'(face);
				r.neg_x = stp[0] < 0;
				r.neg_y = stp[1] < 0;
				r.neg_z = stp[2] < 0;
				r.hit_block = b;
				if (steps == 0) r.distance = 0;
				else if (tm[face] == tvrt_pkg::DIST_MAX) r.distance = tvrt_pkg::DIST_MAX;
				else r.distance = 24'(tm[face] - dlt[face]);
				break;
			end
			if (steps >= limit) break;
			if (tm[0] < tm[1] && tm[0] < tm[2]) a = 0;
			else if (tm[1] < tm[2]) a = 1;
			else a = 2;
			pos[a] += stp[a];
			tm[a] = tm[a] + dlt[a];
			if (tm[a] > tvrt_pkg::DIST_MAX) tm[a] = tvrt_pkg::DIST_MAX;
			face = a;
			steps++;
		end
		return r;
	endfunction

	// Accepted input: update the grid or queue the expected cast result
	function void note_input(tvrt_pkg::cmd_t c);
		bit [3:0] old;
		int ci;
		if (c.command == tvrt_pkg::CMD_WRITE) begin
			old = cell_at(c.write_x, c.write_y, c.write_z);
			ci = chunk_of(c.write_x, c.write_y, c.write_z);
			if (old != 0 && c.write_block == 0 && solid_cnt[ci] > 0) solid_cnt[ci]--;
			else if (old == 0 && c.write_block != 0) solid_cnt[ci]++;
			grid[(int'(c.write_z) * 64 + int'(c.write_y)) * 64 + int'(c.write_x)] =
				c.write_block;
		end else
			pending.push_back(trace_ray(c));
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch: %s got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task check_result(tvrt_pkg::res_t r);
		tvrt_pkg::res_t e;
		if (pending.size() == 0) begin
			report("unexpected result", longint'(r), 0);
			return;
		end
		e = pending.pop_front();
		casts_checked++;
		if (e.hit) hits_seen++;
		if (r.hit != e.hit) report("hit", r.hit, e.hit);
		if (r.hit_x != e.hit_x) report("hit_x", r.hit_x, e.hit_x);
		if (r.hit_y != e.hit_y) report("hit_y", r.hit_y, e.hit_y);
		if (r.hit_z != e.hit_z) report("hit_z", r.hit_z, e.hit_z);
		if (r.hit_face != e.hit_face) report("hit_face", r.hit_face, e.hit_face);
		if (r.neg_x != e.neg_x) report("neg_x", r.neg_x, e.neg_x);
		if (r.neg_y != e.neg_y) report("neg_y", r.neg_y, e.neg_y);
		if (r.neg_z != e.neg_z) report("neg_z", r.neg_z, e.neg_z);
		if (r.hit_block != e.hit_block) report("hit_block", r.hit_block, e.hit_block);
		if (r.distance != e.distance) report("distance", r.distance, e.distance);
	endtask
endclass

module testbench;
	logic           clk;
	logic           arst_n;
	logic           cmd_valid;
	logic           cmd_stall;
	tvrt_pkg::cmd_t cmd;
	logic           res_valid;
	logic           res_stall;
	tvrt_pkg::res_t res;
	logic           cfg_we;
	logic [1:0]     cfg_index;
	logic [21:0]    cfg_data;

	ray_scoreboard sb;
	longint cycle_count;
	int     hold_off;
	bit     stall_random;

	two_level_voxel_ray_traversal dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Timeout watchdog: clearing pass plus all directed and random transactions, several times over
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd12000000) begin
			$display("timeout");
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk)
		if (arst_n && res_valid && !res_stall) sb.check_result(res);

	// Receiver stall pattern, with one long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			res_stall <= 1;
			hold_off <= hold_off - 1;
		end else if (stall_random)
			res_stall <= ($urandom_range(0, 3) == 0);
		else
			res_stall <= 0;
	end

	task automatic cfg_write(bit [1:0] idx, bit [21:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		sb.set_reg(idx, val);
	endtask

	// Drive one transaction; valid held until accepted
	task automatic send(tvrt_pkg::cmd_t c);
		cmd = c;
		cmd_valid = 1;
		do @(posedge clk); while (cmd_stall);
		sb.note_input(c);
		@(negedge clk);
		cmd_valid = 0;
	endtask

	task automatic random_gap();
		int n;
		if ($urandom_range(0, 2) != 0) return;
		n = $urandom_range(1, 6);
		repeat (n) @(negedge clk);
	endtask

	task automatic put_block(int x, int y, int z, int b);
		tvrt_pkg::cmd_t c;
		c = '0;
		c.command = tvrt_pkg::CMD_WRITE;
		c.write_x = 6'(x); c.write_y = 6'(y); c.write_z = 6'(z);
		c.write_block = 4'(b);
		send(c);
	endtask

	task automatic cast(int dx, int dy, int dz);
		tvrt_pkg::cmd_t c;
		c = $urandom();
		c.write_block = 4'($urandom());
		c.command = tvrt_pkg::CMD_CAST;
		c.dir_x = 16'(dx); c.dir_y = 16'(dy); c.dir_z = 16'(dz);
		send(c);
	endtask

	// Wait until every result is in, plus the write latency
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic int rand_dir();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return -32768;
			2: return 32767;
			3: return int'($urandom_range(0, 200)) - 100;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic bit [21:0] rand_cam();
		case ($urandom_range(0, 3))
			0: return {6'($urandom_range(20, 44)), 16'($urandom())};
			1: return 22'($urandom());
			2: return 22'h3FFFFF;
			default: return {6'($urandom_range(0, 63)), 16'h0000};
		endcase
	endfunction

	initial begin
		int burst;
		sb = new();
		sb.clear_state();
		cycle_count = 0;
		hold_off = 0;
		stall_random = 0;
		cmd_valid = 0;
		cmd = '0;
		res_stall = 0;
		cfg_we = 0;
		cfg_index = tvrt_pkg::REG_CAM_X;
		cfg_data = 0;
		arst_n = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;

		// Directed: camera in the middle, a few blocks around it
		cfg_write(tvrt_pkg::REG_CAM_X, {6'd32, 16'h8000});
		cfg_write(tvrt_pkg::REG_CAM_Y, {6'd32, 16'h4000});
		cfg_write(tvrt_pkg::REG_CAM_Z, {6'd32, 16'hC000});
		cast(32767, 0, 0);
		put_block(40, 32, 32, 15);
		put_block(20, 32, 32, 1);
		put_block(32, 63, 32, 7);
		put_block(32, 32, 0, 9);
		put_block(63, 63, 63, 4);
		cast(32767, 0, 0);
		cast(-32768, 0, 0);
		cast(0, 32767, 0);
		cast(0, 0, 0);
		cast(12000, 9000, -3000);
		put_block(32, 32, 32, 3);
		cast(100, -100, 5);
		put_block(32, 32, 32, 0);
		put_block(32, 32, 32, 0);
		cast(1, 1, 1);
		put_block(20, 32, 32, 0);
		cast(-32768, 0, 0);
		drain();
		cfg_write(tvrt_pkg::REG_LIMIT, 22'd1);
		cast(32767, 0, 0);
		drain();
		cfg_write(tvrt_pkg::REG_LIMIT, 22'd4095);
		cfg_write(tvrt_pkg::REG_CAM_X, 22'h3FFFFF);
		cfg_write(tvrt_pkg::REG_CAM_Y, 22'h3FFFFF);
		cfg_write(tvrt_pkg::REG_CAM_Z, 22'h3FFFFF);
		cast(-20000, -20000, -20000);
		cast(32767, 32767, 32767);
		drain();
		cfg_write(tvrt_pkg::REG_CAM_X, 22'd0);
		cfg_write(tvrt_pkg::REG_CAM_Y, 22'd0);
		cfg_write(tvrt_pkg::REG_CAM_Z, 22'd0);
		cast(30000, 25000, 20000);
		cast(-5, 3, 3);
		drain();

		// Random phases: change settings, then mixed writes and casts
		stall_random = 1;
		for (int ph = 0; ph < 20; ph++) begin
			cfg_write(tvrt_pkg::REG_CAM_X, rand_cam());
			cfg_write(tvrt_pkg::REG_CAM_Y, rand_cam());
			cfg_write(tvrt_pkg::REG_CAM_Z, rand_cam());
			cfg_write(tvrt_pkg::REG_LIMIT, ($urandom_range(0, 4) == 0) ? 22'd4095 :
				22'($urandom_range(1, 200)));
			if (ph == 5) hold_off = 2000;
			for (int n = 0; n < 100; n += burst) begin
				burst = $urandom_range(1, 8);
				for (int k = 0; k < burst; k++) begin
					if ($urandom_range(0, 1) == 0) begin
						// Writes cluster so chunks fill and empty
						if ($urandom_range(0, 3) == 0)
							put_block($urandom_range(0, 63), $urandom_range(0, 63),
								$urandom_range(0, 63), $urandom_range(0, 15));
						else
							put_block($urandom_range(24, 40), $urandom_range(24, 40),
								$urandom_range(24, 40),
								($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
					end else
						cast(rand_dir(), rand_dir(), rand_dir());
				end
				random_gap();
			end
			drain();
		end

		$display("covered %0d casts (%0d hits): directed cases, then 20 random settings",
			sb.casts_checked, sb.hits_seen);
		$display("with mixed writes, random output stalls and one long hold-off");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
rtl/tvrt_pkg.sv
rtl/tvrt_ram.sv
rtl/tvrt_div.sv
rtl/two_level_voxel_ray_traversal.sv
tb/sv/testbench.sv
